// File: rtl/core/url_component_scanner_core_macros.svh
// assertion macros shared by the url component scanner rtl
// no dependencies; taken in by the modules that carry assertions
`ifndef URL_COMPONENT_SCANNER_CORE_MACROS_SVH
`define URL_COMPONENT_SCANNER_CORE_MACROS_SVH

// property checked at every clock edge outside reset
`define UCS_ASSERT_SYNC(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// consequent checked in the cycle after the antecedent holds
`define UCS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/ucs_pkg.sv
// shared types, character codes and constants of the url component scanner
// no dependencies
package ucs_pkg;

    // default longest url accepted, in bytes
    localparam int DEF_MAX_URL_LEN = 4094;

    // stream widths
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 136;

    // boundary offsets
    localparam int OFS_W   = 12;
    localparam int NUM_OFS = 10;
    localparam logic [OFS_W-1:0] ABSENT = 12'hfff;

    localparam int OFS_SCHEMA_END = 0;
    localparam int OFS_HOST_START = 1;
    localparam int OFS_HOST_END   = 2;
    localparam int OFS_PORT_END   = 3;
    localparam int OFS_URI_START  = 4;
    localparam int OFS_URI_END    = 5;
    localparam int OFS_ARGS_START = 6;
    localparam int OFS_FRAG_START = 7;
    localparam int OFS_UP_START   = 8;
    localparam int OFS_UP_END     = 9;

    typedef logic [NUM_OFS-1:0][OFS_W-1:0] ofs_arr_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_INVALID  = 2'd1,
        STATUS_TOO_LONG = 2'd2
    } status_t;

    typedef struct packed {
        status_t           status;
        ofs_arr_t          offs;
        logic [OFS_W-1:0]  url_end;
    } result_t;

    // parser states, one-hot
    typedef enum logic [10:0] {
        ST_SCHEMA      = 11'b000_0000_0001,
        ST_SLASH1      = 11'b000_0000_0010,
        ST_SLASH2      = 11'b000_0000_0100,
        ST_HOST_START  = 11'b000_0000_1000,
        ST_HOST        = 11'b000_0001_0000,
        ST_HOST_END    = 11'b000_0010_0000,
        ST_IP_LIT      = 11'b000_0100_0000,
        ST_PORT        = 11'b000_1000_0000,
        ST_AFTER_SLASH = 11'b001_0000_0000,
        ST_CHECK_PATH  = 11'b010_0000_0000,
        ST_PATH        = 11'b100_0000_0000
    } parse_state_t;

    // byte classes
    typedef struct packed {
        logic is_letter;
        logic is_digit;
        logic is_usual;
        logic is_ip_sym;
    } char_class_t;

    // usual path characters, bit n set for byte value n
    localparam logic [255:0] USUAL_MASK = {
        32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
        32'hffffffff, 32'hffffffff, 32'h7fff37d6, 32'hffffdbfe
    };

    // character codes
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_QUOTE   = 8'h27;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_STAR    = 8'h2a;
    localparam logic [7:0] CH_PLUS    = 8'h2b;
    localparam logic [7:0] CH_COMMA   = 8'h2c;
    localparam logic [7:0] CH_MINUS   = 8'h2d;
    localparam logic [7:0] CH_DOT     = 8'h2e;
    localparam logic [7:0] CH_SLASH   = 8'h2f;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_COLON   = 8'h3a;
    localparam logic [7:0] CH_SEMI    = 8'h3b;
    localparam logic [7:0] CH_EQUALS  = 8'h3d;
    localparam logic [7:0] CH_QUEST   = 8'h3f;
    localparam logic [7:0] CH_AT      = 8'h40;
    localparam logic [7:0] CH_LBRACK  = 8'h5b;
    localparam logic [7:0] CH_RBRACK  = 8'h5d;
    localparam logic [7:0] CH_USCORE  = 8'h5f;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7a;
    localparam logic [7:0] CH_TILDE   = 8'h7e;
    localparam logic [7:0] CASE_BIT   = 8'h20;

endpackage

// File: rtl/core/ucs_char_class.sv
// byte classifier of the url component scanner: letter, digit, usual, ip literal symbol
// depends on ucs_pkg
module ucs_char_class import ucs_pkg::*; (
    input  logic [7:0]  ch,
    output char_class_t cls
);

    logic [7:0] lc;
    logic       ip_sym;

    // letter test on the lower-case folded byte
    assign lc            = ch | CASE_BIT;
    assign cls.is_letter = (lc >= CH_LOWER_A) && (lc <= CH_LOWER_Z);
    assign cls.is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign cls.is_usual  = USUAL_MASK[ch];
    assign cls.is_ip_sym = ip_sym;

    // punctuation allowed inside a bracketed literal
    always_comb begin
        unique case (ch) inside
            CH_COLON, CH_MINUS, CH_DOT, CH_USCORE, CH_TILDE, CH_BANG, CH_DOLLAR,
            CH_AMP, CH_QUOTE, CH_LPAREN, CH_RPAREN, CH_STAR, CH_PLUS, CH_COMMA,
            CH_SEMI, CH_EQUALS: ip_sym = 1'b1;
            default:            ip_sym = 1'b0;
        endcase
    end

endmodule

// File: rtl/core/ucs_parser.sv
// url parse state machine: state, byte position, boundary offsets and error flag
// depends on ucs_pkg, ucs_char_class and url_component_scanner_core_macros.svh
`include "url_component_scanner_core_macros.svh"

module ucs_parser import ucs_pkg::*; #(
    parameter int MAX_URL_LEN = DEF_MAX_URL_LEN
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       fire,
    input  logic [7:0] ch,
    output logic       res_valid,
    output result_t    res
);

    localparam int PW = $clog2(MAX_URL_LEN + 1);

    typedef enum logic [1:0] {
        RC_CONT    = 2'd0,
        RC_DONE    = 2'd1,
        RC_INVALID = 2'd2
    } step_rc_t;

    parse_state_t     state_reg, state_next;
    logic [PW-1:0]    pos_reg, pos_next;
    ofs_arr_t         offs_reg, offs_next;
    logic             err_seen_reg, err_seen_next;
    char_class_t      cls;
    logic [OFS_W-1:0] p12, p_inc, p_dec;
    logic             host_ch;
    logic             host_end;
    logic             rearm;
    step_rc_t         rc;

    ucs_char_class u_class (
        .ch  (ch),
        .cls (cls)
    );

    assign p12     = OFS_W'(pos_reg);
    assign p_inc   = p12 + 1'b1;
    assign p_dec   = p12 - 1'b1;
    assign host_ch = cls.is_letter || cls.is_digit || (ch == CH_DOT) || (ch == CH_MINUS);

    // one byte step
    always_comb begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        offs_next     = offs_reg;
        err_seen_next = err_seen_reg;
        res_valid     = 1'b0;
        res.status    = STATUS_OK;
        res.offs      = offs_reg;
        res.url_end   = ABSENT;
        rc            = RC_CONT;
        host_end      = 1'b0;
        rearm         = 1'b0;

        if (fire) begin
            if (err_seen_reg) begin
                // swallow bytes up to the next terminator
                if (ch == CH_NUL) begin
                    err_seen_next = 1'b0;
                    rearm         = 1'b1;
                end
            end else if ((ch != CH_NUL) && (pos_reg >= PW'(MAX_URL_LEN))) begin
                res_valid     = 1'b1;
                res.status    = STATUS_TOO_LONG;
                err_seen_next = 1'b1;
                rearm         = 1'b1;
            end else begin
                unique case (state_reg)
                    ST_SCHEMA: begin
                        if (cls.is_letter) begin
                            rc = RC_CONT;
                        end else if (ch == CH_COLON) begin
                            offs_next[OFS_SCHEMA_END] = p12;
                            state_next                = ST_SLASH1;
                        end else begin
                            rc = RC_INVALID;
                        end
                    end
                    ST_SLASH1: begin
                        if (ch == CH_SLASH) state_next = ST_SLASH2;
                        else                rc = RC_INVALID;
                    end
                    ST_SLASH2: begin
                        if (ch == CH_SLASH) state_next = ST_HOST_START;
                        else                rc = RC_INVALID;
                    end
                    ST_HOST_START: begin
                        offs_next[OFS_HOST_START] = p12;
                        if (ch == CH_LBRACK) begin
                            state_next = ST_IP_LIT;
                        end else begin
                            state_next = ST_HOST;
                            host_end   = !host_ch;
                        end
                    end
                    ST_HOST: begin
                        host_end = !host_ch;
                    end
                    ST_HOST_END: begin
                        host_end = 1'b1;
                    end
                    ST_IP_LIT: begin
                        if (cls.is_digit || cls.is_letter || cls.is_ip_sym) begin
                            rc = RC_CONT;
                        end else if (ch == CH_RBRACK) begin
                            state_next = ST_HOST_END;
                        end else begin
                            rc = RC_INVALID;
                        end
                    end
                    ST_PORT: begin
                        if (cls.is_digit) begin
                            rc = RC_CONT;
                        end else if (ch == CH_NUL) begin
                            offs_next[OFS_PORT_END] = p12;
                            rc                      = RC_DONE;
                        end else if (ch == CH_SLASH) begin
                            offs_next[OFS_PORT_END]  = p12;
                            offs_next[OFS_URI_START] = p12;
                            state_next               = ST_AFTER_SLASH;
                        end else if (ch == CH_AT) begin
                            // what looked like host:port was user:pass
                            offs_next[OFS_UP_END]     = p12;
                            offs_next[OFS_UP_START]   = offs_reg[OFS_HOST_START];
                            offs_next[OFS_HOST_START] = ABSENT;
                            offs_next[OFS_PORT_END]   = ABSENT;
                            state_next                = ST_HOST_START;
                        end
                    end
                    ST_AFTER_SLASH: begin
                        if (cls.is_usual) begin
                            state_next = ST_CHECK_PATH;
                        end else begin
                            case (ch) inside
                                CH_DOT, CH_PERCENT, CH_SLASH: state_next = ST_PATH;
                                CH_QUEST: begin
                                    offs_next[OFS_URI_END]    = p_dec;
                                    offs_next[OFS_ARGS_START] = p_inc;
                                    state_next                = ST_PATH;
                                end
                                CH_HASH: begin
                                    offs_next[OFS_FRAG_START] = p_inc;
                                    state_next                = ST_PATH;
                                end
                                CH_PLUS: rc = RC_CONT;
                                CH_NUL: begin
                                    offs_next[OFS_URI_END] = p12;
                                    rc                     = RC_DONE;
                                end
                                default: state_next = ST_CHECK_PATH;
                            endcase
                        end
                    end
                    ST_CHECK_PATH: begin
                        if (!cls.is_usual) begin
                            case (ch)
                                CH_SLASH:   state_next = ST_AFTER_SLASH;
                                CH_PERCENT: state_next = ST_PATH;
                                CH_QUEST: begin
                                    offs_next[OFS_ARGS_START] = p_inc;
                                    state_next                = ST_PATH;
                                end
                                CH_HASH: begin
                                    offs_next[OFS_FRAG_START] = p_inc;
                                    state_next                = ST_PATH;
                                end
                                CH_NUL: begin
                                    offs_next[OFS_URI_END] = p12;
                                    rc                     = RC_DONE;
                                end
                                default: rc = RC_CONT;
                            endcase
                        end
                    end
                    ST_PATH: begin
                        if (!cls.is_usual) begin
                            if (ch == CH_NUL) begin
                                offs_next[OFS_URI_END] = p12;
                                rc                     = RC_DONE;
                            end else if (ch == CH_HASH) begin
                                offs_next[OFS_FRAG_START] = p_inc;
                            end
                        end
                    end
                    default: rc = RC_INVALID;
                endcase

                // byte that ends the host name
                if (host_end) begin
                    offs_next[OFS_HOST_END] = p12;
                    case (ch)
                        CH_COLON: state_next = ST_PORT;
                        CH_SLASH: begin
                            offs_next[OFS_URI_START] = p12;
                            state_next               = ST_AFTER_SLASH;
                        end
                        CH_QUEST: begin
                            offs_next[OFS_ARGS_START] = p_inc;
                            state_next                = ST_PATH;
                        end
                        CH_HASH: begin
                            offs_next[OFS_FRAG_START] = p_inc;
                            state_next                = ST_PATH;
                        end
                        CH_NUL:  rc = RC_DONE;
                        default: rc = RC_INVALID;
                    endcase
                end

                // outcome of the step
                case (rc)
                    RC_CONT: pos_next = pos_reg + 1'b1;
                    RC_DONE: begin
                        res_valid   = 1'b1;
                        res.status  = STATUS_OK;
                        res.offs    = offs_next;
                        res.url_end = p12;
                        rearm       = 1'b1;
                    end
                    default: begin
                        res_valid     = 1'b1;
                        res.status    = STATUS_INVALID;
                        res.offs      = offs_next;
                        rearm         = 1'b1;
                        err_seen_next = (ch != CH_NUL);
                    end
                endcase
            end
        end

        // back to the start for the next url
        if (rearm) begin
            state_next = ST_SCHEMA;
            pos_next   = '0;
            offs_next  = {NUM_OFS{ABSENT}};
        end
    end

    // parse state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_SCHEMA;
            pos_reg      <= '0;
            offs_reg     <= {NUM_OFS{ABSENT}};
            err_seen_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pos_reg      <= pos_next;
            offs_reg     <= offs_next;
            err_seen_reg <= err_seen_next;
        end
    end

    // checks
    `UCS_ASSERT_SYNC(a_err_rearmed, aclk, aresetn,
        err_seen_reg |-> (state_reg == ST_SCHEMA && pos_reg == '0),
        "error skip entered without rearming")
    `UCS_ASSERT_SYNC(a_pos_bound, aclk, aresetn,
        pos_reg <= PW'(MAX_URL_LEN),
        "byte position beyond supported length")
    `UCS_ASSERT_SYNC(a_state_onehot, aclk, aresetn,
        $onehot(state_reg),
        "parse state not one-hot")

endmodule

// File: rtl/core/url_component_scanner_core.sv
// url component scanner: input register, parse step, result register
// an accepted byte is held in the input register, parsed from there, and its result is stored in the result register
// throughput: one byte per cycle while m_tready is high; one result per url
// a result waits in the result register while the next byte is taken
// reset (aresetn low, synchronous) empties both registers and rearms the parser
// depends on ucs_pkg, ucs_parser and url_component_scanner_core_macros.svh
`include "url_component_scanner_core_macros.svh"

module url_component_scanner_core import ucs_pkg::*; #(
    parameter int MAX_URL_LEN = DEF_MAX_URL_LEN
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [7:0] char_byte
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [1:0] status, then 12 bits each: scheme_colon, host_first, host_stop,
    // port_stop, path_first, uri_end, query_first, frag_first,
    // login_first, login_stop, url_end; [135:134] zero
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg, out_valid_next;
    result_t    out_reg;
    logic       proc_fire;
    logic       s_fire;
    logic       res_valid;
    result_t    res;

    // a byte is processed when the result slot is free or being emptied
    assign proc_fire = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || proc_fire;
    assign s_fire    = s_tvalid && s_tready;

    ucs_parser #(
        .MAX_URL_LEN (MAX_URL_LEN)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (proc_fire),
        .ch        (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // input register
    assign in_valid_next = s_fire ? 1'b1 : (proc_fire ? 1'b0 : in_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_byte_reg <= s_tdata;
        end
    end

    // result register
    assign out_valid_next = (out_valid_reg && !m_tready) || (proc_fire && res_valid);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_fire && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg.url_end, out_reg.offs, out_reg.status};

    // checks
    `UCS_ASSERT_NEXT(a_in_hold, aclk, aresetn,
        in_valid_reg && !proc_fire,
        in_valid_reg && $stable(in_byte_reg),
        "pending byte lost before processing")
    `UCS_ASSERT_SYNC(a_res_source, aclk, aresetn,
        $rose(out_valid_reg) |-> $past(proc_fire && res_valid),
        "result appeared without a processed byte")
    `UCS_ASSERT_SYNC(a_url_end_absent, aclk, aresetn,
        out_valid_reg |-> (out_reg.status == STATUS_OK || out_reg.url_end == ABSENT),
        "failed parse carries a url end offset")

endmodule
